>>> src/tvc_pkg.sv
// ----------------------------------------------------------------------------
// tvc_pkg
// Types and codes shared by the termination vote controller modules.
// ----------------------------------------------------------------------------
package tvc_pkg;

   // Field widths fixed by the interface
   localparam int OP_W         = 2;
   localparam int ITEM_COUNT_W = 16;
   localparam int MSG_W        = 3;
   localparam int SEND_W       = 3;
   localparam int NODE_COUNT_W = 11;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 11;

   // Operations
   localparam logic [OP_W-1:0] OP_SENT = 2'd0;
   localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
   localparam logic [OP_W-1:0] OP_MSG  = 2'd2;
   localparam logic [OP_W-1:0] OP_POLL = 2'd3;

   // Arriving message kinds
   localparam logic [MSG_W-1:0] MSG_PROPOSE     = 3'd0;
   localparam logic [MSG_W-1:0] MSG_VOTE_COMMIT = 3'd1;
   localparam logic [MSG_W-1:0] MSG_VOTE_ABORT  = 3'd2;
   localparam logic [MSG_W-1:0] MSG_DO_COMMIT   = 3'd3;
   localparam logic [MSG_W-1:0] MSG_DO_ABORT    = 3'd4;

   // Outgoing message kinds
   localparam logic [SEND_W-1:0] SEND_NONE        = 3'd0;
   localparam logic [SEND_W-1:0] SEND_VOTE_COMMIT = 3'd1;
   localparam logic [SEND_W-1:0] SEND_VOTE_ABORT  = 3'd2;
   localparam logic [SEND_W-1:0] SEND_PROPOSE     = 3'd3;
   localparam logic [SEND_W-1:0] SEND_DO_COMMIT   = 3'd4;
   localparam logic [SEND_W-1:0] SEND_DO_ABORT    = 3'd5;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IS_COORDINATOR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_COUNT     = 1'd1;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic [ITEM_COUNT_W-1:0] item_count;
      logic [MSG_W-1:0]        message_kind;
      logic                    queue_empty;
   } req_type;

   typedef struct packed {
      logic [SEND_W-1:0] send_kind;
      logic              send_to_all;
      logic              done_res;
      logic              count_error;
   } rsp_type;

   // Configuration as seen by the core
   typedef struct packed {
      logic                    is_coordinator;
      logic [NODE_COUNT_W-1:0] node_count;
      logic                    role_write;
      logic                    role_value;
   } cfg_type;

endpackage

>>> src/termination_vote_controller.sv
// Path: a request waits in the input register, then its result enters the response queue.
// Throughput: one request per cycle, sustained while the response side keeps up;
// the input register and the two-entry response queue set this figure.
// Reset: synchronous, active high; the node comes up as an idle cohort with no
// pending work, one participating node and empty vote counts.
// ----------------------------------------------------------------------------
// termination_vote_controller
// Two-phase commit termination voter for one node of a distributed job.
// ----------------------------------------------------------------------------
module termination_vote_controller #(
   parameter int MAX_NODES     = 1024,
   parameter int PENDING_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tvc_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tvc_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [tvc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tvc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tvc_pkg::*;

   logic                    stage_valid_ff, stage_valid_in;
   req_type                 stage_item_ff;
   logic                    is_coord_ff,    is_coord_in;
   logic [NODE_COUNT_W-1:0] node_count_ff,  node_count_in;
   cfg_type                 cfg;
   logic                    advance;
   logic                    push_room;
   rsp_type                 core_result;

   // Step the staged request once the queue has room
   assign advance   = stage_valid_ff && push_room;
   assign req_ready = !stage_valid_ff || advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_valid && req_ready) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Capture the request on transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_item_ff <= req_payload;
      end
   end

   // Configuration registers
   always_comb begin
      is_coord_in   = is_coord_ff;
      node_count_in = node_count_ff;
      if (csr_wr_en && csr_index == CSR_IS_COORDINATOR) begin
         is_coord_in = csr_wdata[0];
      end
      if (csr_wr_en && csr_index == CSR_NODE_COUNT) begin
         node_count_in = csr_wdata[NODE_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_coord_ff   <= 1'b0;
         node_count_ff <= NODE_COUNT_W'(1);
      end else begin
         is_coord_ff   <= is_coord_in;
         node_count_ff <= node_count_in;
      end
   end

   always_comb begin
      cfg.is_coordinator = is_coord_ff;
      cfg.node_count     = node_count_ff;
      cfg.role_write     = csr_wr_en && (csr_index == CSR_IS_COORDINATOR);
      cfg.role_value     = csr_wdata[0];
   end

   tvc_core #(
      .MAX_NODES     (MAX_NODES),
      .PENDING_WIDTH (PENDING_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .item   (stage_item_ff),
      .result (core_result)
   );

   tvc_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (advance),
      .push_data   (core_result),
      .push_room   (push_room),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> src/tvc_core.sv
// ----------------------------------------------------------------------------
// tvc_core
// Protocol state, pending-work counter and vote counters; computes the
// result of one event and updates the state when the event is stepped.
// ----------------------------------------------------------------------------
module tvc_core #(
   parameter int MAX_NODES     = 1024,
   parameter int PENDING_WIDTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  tvc_pkg::cfg_type cfg,
   input  logic            step,
   input  tvc_pkg::req_type item,
   output tvc_pkg::rsp_type result
);
   import tvc_pkg::*;

   // Protocol states
   localparam logic [2:0] ST_IDLE_COORD  = 3'd0;
   localparam logic [2:0] ST_IDLE_COHORT = 3'd1;
   localparam logic [2:0] ST_WAIT_VOTE   = 3'd2;
   localparam logic [2:0] ST_WAIT_RESULT = 3'd3;
   localparam logic [2:0] ST_TERMINATE   = 3'd4;

   localparam int PW     = PENDING_WIDTH;
   localparam int CW     = (PW > ITEM_COUNT_W) ? PW : ITEM_COUNT_W;
   localparam int SUM_W  = CW + 1;
   localparam int VOTE_W = $clog2(MAX_NODES);
   localparam int MN_W   = $clog2(MAX_NODES + 1);
   localparam int NC_W   = (NODE_COUNT_W > MN_W) ? NODE_COUNT_W : MN_W;
   localparam logic [PW-1:0]   PEND_MAX = '1;
   localparam logic [NC_W-1:0] NC_MAX   = NC_W'(MAX_NODES);
   localparam logic [NC_W-1:0] NC_ONE   = NC_W'(1);

   logic [2:0]        state_ff,   state_in;
   logic [PW-1:0]     pend_ff,    pend_in;
   logic [VOTE_W-1:0] votes_ff,   votes_in;
   logic [VOTE_W-1:0] commits_ff, commits_in;

   logic [NC_W-1:0]   nc_ext;
   logic [NC_W-1:0]   nc_clamped;
   logic [VOTE_W-1:0] others;
   logic              has_work;
   logic [SUM_W-1:0]  pend_sum;
   logic [CW-1:0]     pend_wide;
   logic [CW-1:0]     cnt_wide;
   logic [CW-1:0]     pend_diff;
   logic [VOTE_W-1:0] votes_inc;
   logic [VOTE_W-1:0] commits_inc;

   // Number of other nodes, node count clamped to one..MAX_NODES
   assign nc_ext = NC_W'(cfg.node_count);
   always_comb begin
      if (nc_ext == '0) begin
         nc_clamped = NC_ONE;
      end else if (nc_ext > NC_MAX) begin
         nc_clamped = NC_MAX;
      end else begin
         nc_clamped = nc_ext;
      end
   end
   assign others = VOTE_W'(nc_clamped - NC_ONE);

   // Work is outstanding unless the queue is empty and nothing is pending
   assign has_work = !(item.queue_empty && (pend_ff == '0));

   // Pending counter arithmetic
   assign pend_wide = CW'(pend_ff);
   assign cnt_wide  = CW'(item.item_count);
   assign pend_sum  = SUM_W'(pend_ff) + SUM_W'(item.item_count);
   assign pend_diff = pend_wide - cnt_wide;

   // Vote counters after this vote
   assign votes_inc   = votes_ff + VOTE_W'(1);
   assign commits_inc = commits_ff +
                        VOTE_W'(item.message_kind == MSG_VOTE_COMMIT);

   // Next state and result of the event
   always_comb begin
      state_in   = state_ff;
      pend_in    = pend_ff;
      votes_in   = votes_ff;
      commits_in = commits_ff;
      result     = '0;
      if (cfg.role_write) begin
         state_in   = cfg.role_value ? ST_IDLE_COORD : ST_IDLE_COHORT;
         pend_in    = '0;
         votes_in   = '0;
         commits_in = '0;
      end else if (step) begin
         case (item.operation)
            OP_SENT: begin
               if (pend_sum > SUM_W'(PEND_MAX)) begin
                  pend_in = PEND_MAX;
               end else begin
                  pend_in = PW'(pend_sum);
               end
            end
            OP_ACK: begin
               if (cnt_wide > pend_wide) begin
                  pend_in            = '0;
                  result.count_error = 1'b1;
               end else begin
                  pend_in = PW'(pend_diff);
               end
            end
            OP_MSG: begin
               case (state_ff)
                  ST_IDLE_COHORT: begin
                     if (item.message_kind == MSG_PROPOSE) begin
                        state_in         = ST_WAIT_RESULT;
                        result.send_kind = has_work ? SEND_VOTE_ABORT
                                                    : SEND_VOTE_COMMIT;
                     end
                  end
                  ST_WAIT_RESULT: begin
                     if (item.message_kind == MSG_DO_COMMIT) begin
                        state_in = ST_TERMINATE;
                     end else if (item.message_kind == MSG_DO_ABORT) begin
                        state_in = ST_IDLE_COHORT;
                     end
                  end
                  ST_WAIT_VOTE: begin
                     if (item.message_kind == MSG_VOTE_COMMIT ||
                         item.message_kind == MSG_VOTE_ABORT) begin
                        if (votes_inc >= others) begin
                           // All others have voted: broadcast the decision
                           result.send_to_all = 1'b1;
                           if (!has_work && commits_inc >= others) begin
                              state_in         = ST_TERMINATE;
                              result.send_kind = SEND_DO_COMMIT;
                           end else begin
                              state_in         = ST_IDLE_COORD;
                              result.send_kind = SEND_DO_ABORT;
                           end
                           votes_in   = '0;
                           commits_in = '0;
                        end else begin
                           votes_in   = votes_inc;
                           commits_in = commits_inc;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            OP_POLL: begin
               // Idle coordinator with no work proposes termination
               if (cfg.is_coordinator && state_ff == ST_IDLE_COORD && !has_work) begin
                  state_in           = ST_WAIT_VOTE;
                  result.send_kind   = SEND_PROPOSE;
                  result.send_to_all = 1'b1;
               end
               // Report termination and restart the node
               if (state_ff == ST_TERMINATE) begin
                  result.done_res = 1'b1;
                  state_in   = cfg.is_coordinator ? ST_IDLE_COORD : ST_IDLE_COHORT;
                  pend_in    = '0;
                  votes_in   = '0;
                  commits_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE_COHORT;
         pend_ff    <= '0;
         votes_ff   <= '0;
         commits_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         votes_ff   <= votes_in;
         commits_ff <= commits_in;
      end
   end

endmodule

>>> src/tvc_rsp_fifo.sv
// ----------------------------------------------------------------------------
// tvc_rsp_fifo
// Two-entry result queue that parts the core from the result channel.
// ----------------------------------------------------------------------------
module tvc_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tvc_pkg::rsp_type push_data,
   output logic             push_room,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tvc_pkg::rsp_type rsp_payload
);
   import tvc_pkg::*;

   rsp_type    data_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       pop;

   assign push_room   = (count_ff != 2'd2);
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = data_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed result
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
